>>> rtl/core/pdfm_pkg.sv
// pwm duty and frequency meter: shared constants, word types and control structs
// used by every module of the meter; depends on nothing
`timescale 1ns / 1ps

package pdfm_pkg;

    // window and field sizes
    localparam int WINDOW_PAIRS = 16;
    localparam int TIME_W       = 32;
    localparam int SUM_W        = 48;
    localparam int COUNT_W      = 8;
    localparam int CLOCK_W      = 28;
    localparam int PERIOD_W     = 32;
    localparam int DUTY_W       = 14;
    localparam int TICKS_W      = TIME_W + 1;

    // constant factors
    localparam int NS_W  = 30;
    localparam int PROD_NS_W   = TICKS_W + NS_W;
    localparam int PROD_DUTY_W = TIME_W + DUTY_W;
    localparam logic [NS_W-1:0]    NS_PER_SECOND = NS_W'(1000000000);
    localparam logic [DUTY_W-1:0]  DUTY_SCALE    = DUTY_W'(10000);
    localparam logic [CLOCK_W-1:0] CLOCK_HZ_RESET = CLOCK_W'(120000000);
    localparam logic [COUNT_W-1:0] LAST_PAIR     = COUNT_W'(WINDOW_PAIRS - 1);

    // serial divider sizes
    localparam int DIV_NUM_W = 64;
    localparam int DIV_DEN_W = TICKS_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);
    localparam logic [DIV_CNT_W-1:0] DIV_LAST_STEP = DIV_CNT_W'(DIV_NUM_W - 1);

    // input word: one captured edge pair
    typedef struct packed {
        logic [TIME_W-1:0] rise_time;
        logic [TIME_W-1:0] fall_time;
    } t_in_word;

    // output word: one window result
    typedef struct packed {
        logic [PERIOD_W-1:0] period_ns;
        logic [CLOCK_W-1:0]  frequency_hz;
        logic [DUTY_W-1:0]   duty_hundredths;
        logic                no_signal;
    } t_out_word;

    // divide operations run at window end
    typedef enum logic [2:0] {
        OP_AVG_HIGH = 3'd0,
        OP_AVG_LOW  = 3'd1,
        OP_PERIOD   = 3'd2,
        OP_FREQ     = 3'd3,
        OP_DUTY     = 3'd4
    } t_div_op;

    // controller to datapath
    typedef struct packed {
        logic    accept;
        logic    init;
        logic    div_start;
        t_div_op div_op;
        logic    sum_ticks;
        logic    mul;
        logic    load;
    } t_ctrl_cmd;

    // datapath to controller
    typedef struct packed {
        logic window_end;
        logic high_zero;
        logic low_zero;
        logic clock_zero;
        logic div_done;
    } t_dp_status;

endpackage

>>> rtl/core/pwm_duty_frequency_meter.sv
// pwm duty meter top: one edge pair per word; a word that does not close a window
// is taken without a stall, and the input stalls only for window-end processing.
// the closing word gives its result after up to five divides on one shared serial
// divider, the tick sum and product steps, and a load that waits for the output
// to be free; the input accepts again the cycle after the result loads.
// reset is synchronous, active low; it clears the sums, the last fall time and
// the output valid, and sets the timer clock register to 120 MHz
`timescale 1ns / 1ps

module pwm_duty_frequency_meter (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  pdfm_pkg::t_in_word             i_in_word,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output pdfm_pkg::t_out_word            o_out_word,
    input  logic                           i_cfg_we,
    input  logic [pdfm_pkg::CLOCK_W-1:0]   i_cfg_data
);
    import pdfm_pkg::*;

    t_ctrl_cmd  cmd;
    t_dp_status status;

    // sequencing and handshakes
    pdfm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    // sums, divider and result word
    pdfm_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_in_word  (i_in_word),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .o_status   (status),
        .o_out_word (o_out_word)
    );

endmodule

>>> rtl/core/pdfm_div.sv
// pwm meter: restoring serial divider, one quotient bit per cycle
// depends on pdfm_pkg for operand widths
`timescale 1ns / 1ps

module pdfm_div (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [pdfm_pkg::DIV_NUM_W-1:0]   i_numer,
    input  logic [pdfm_pkg::DIV_DEN_W-1:0]   i_denom,
    output logic                             o_done,
    output logic [pdfm_pkg::DIV_NUM_W-1:0]   o_quot
);
    import pdfm_pkg::*;

    logic [DIV_NUM_W-1:0] r_quo;
    logic [DIV_DEN_W-1:0] r_rem;
    logic [DIV_DEN_W-1:0] r_den;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_busy;
    logic                 r_done;

    logic [DIV_DEN_W:0]   rem_sh;
    logic [DIV_DEN_W:0]   rem_sub;
    logic                 fits;

    // trial subtract of the shifted partial remainder
    always_comb begin
        rem_sh  = {r_rem, r_quo[DIV_NUM_W-1]};
        rem_sub = rem_sh - {1'b0, r_den};
        fits    = (rem_sh >= {1'b0, r_den});
    end

    // control: step counter and done pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == DIV_LAST_STEP);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == DIV_LAST_STEP) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // operands: numerator shifts out as quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_numer;
            r_rem <= '0;
            r_den <= i_denom;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIV_NUM_W-2:0], fits};
            r_rem <= fits ? rem_sub[DIV_DEN_W-1:0] : rem_sh[DIV_DEN_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;

endmodule

>>> rtl/core/pdfm_datapath.sv
// pwm meter datapath: interval sums, clock register, shared divider,
// products and the output word register; depends on pdfm_pkg and pdfm_div
`timescale 1ns / 1ps

module pdfm_datapath (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  pdfm_pkg::t_ctrl_cmd            i_cmd,
    input  pdfm_pkg::t_in_word             i_in_word,
    input  logic                           i_cfg_we,
    input  logic [pdfm_pkg::CLOCK_W-1:0]   i_cfg_data,
    output pdfm_pkg::t_dp_status           o_status,
    output pdfm_pkg::t_out_word            o_out_word
);
    import pdfm_pkg::*;

    logic [CLOCK_W-1:0]     r_clock_hz;
    logic [TIME_W-1:0]      r_last_fall;
    logic [SUM_W-1:0]       r_high_sum;
    logic [SUM_W-1:0]       r_low_sum;
    logic [COUNT_W-1:0]     r_pair_index;
    logic [COUNT_W-1:0]     r_high_valid;
    logic [COUNT_W-1:0]     r_low_valid;

    logic [TIME_W-1:0]      r_avg_high;
    logic [TIME_W-1:0]      r_avg_low;
    logic [TICKS_W-1:0]     r_ticks;
    logic [PROD_NS_W-1:0]   r_prod_ns;
    logic [PROD_DUTY_W-1:0] r_prod_duty;
    logic [PERIOD_W-1:0]    r_period;
    logic [CLOCK_W-1:0]     r_freq;
    logic [DUTY_W-1:0]      r_duty;
    t_div_op                r_op;
    t_out_word              r_out_word;

    logic                   high_ok;
    logic                   low_ok;
    logic [TIME_W-1:0]      high_len;
    logic [TIME_W-1:0]      low_len;
    logic [DIV_NUM_W-1:0]   div_numer;
    logic [DIV_DEN_W-1:0]   div_denom;
    logic                   div_done;
    logic [DIV_NUM_W-1:0]   div_quot;
    logic                   no_signal;

    // interval checks for the incoming pair
    always_comb begin
        high_ok  = (r_pair_index != '0) && (i_in_word.fall_time > i_in_word.rise_time);
        low_ok   = (r_pair_index != '0) && (i_in_word.rise_time > r_last_fall);
        high_len = i_in_word.fall_time - i_in_word.rise_time;
        low_len  = i_in_word.rise_time - r_last_fall;
    end

    // clock register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clock_hz <= CLOCK_HZ_RESET;
        end else if (i_cfg_we) begin
            r_clock_hz <= i_cfg_data;
        end
    end

    // window accumulation, cleared when the result is loaded
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_fall  <= '0;
            r_high_sum   <= '0;
            r_low_sum    <= '0;
            r_pair_index <= '0;
            r_high_valid <= '0;
            r_low_valid  <= '0;
        end else if (i_cmd.load) begin
            r_high_sum   <= '0;
            r_low_sum    <= '0;
            r_pair_index <= '0;
            r_high_valid <= '0;
            r_low_valid  <= '0;
        end else if (i_cmd.accept) begin
            r_last_fall  <= i_in_word.fall_time;
            r_pair_index <= r_pair_index + 1'b1;
            if (high_ok) begin
                r_high_sum   <= r_high_sum + SUM_W'(high_len);
                r_high_valid <= r_high_valid + 1'b1;
            end
            if (low_ok) begin
                r_low_sum   <= r_low_sum + SUM_W'(low_len);
                r_low_valid <= r_low_valid + 1'b1;
            end
        end
    end

    // divider operand select
    always_comb begin
        case (i_cmd.div_op)
            OP_AVG_HIGH: begin
                div_numer = DIV_NUM_W'(r_high_sum);
                div_denom = DIV_DEN_W'(r_high_valid);
            end
            OP_AVG_LOW: begin
                div_numer = DIV_NUM_W'(r_low_sum);
                div_denom = DIV_DEN_W'(r_low_valid);
            end
            OP_PERIOD: begin
                div_numer = DIV_NUM_W'(r_prod_ns);
                div_denom = DIV_DEN_W'(r_clock_hz);
            end
            OP_FREQ: begin
                div_numer = DIV_NUM_W'(r_clock_hz);
                div_denom = r_ticks;
            end
            OP_DUTY: begin
                div_numer = DIV_NUM_W'(r_prod_duty);
                div_denom = r_ticks;
            end
            default: begin
                div_numer = '0;
                div_denom = '0;
            end
        endcase
    end

    pdfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start),
        .i_numer (div_numer),
        .i_denom (div_denom),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    // operation tag follows the divider
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op <= OP_AVG_HIGH;
        end else if (i_cmd.div_start) begin
            r_op <= i_cmd.div_op;
        end
    end

    // result registers: preset for skipped divides, then filled by the divider
    always_ff @(posedge i_clk) begin
        if (i_cmd.init) begin
            r_avg_high <= '0;
            r_avg_low  <= '0;
            r_period   <= '1;
            r_freq     <= '0;
            r_duty     <= '0;
        end else if (div_done) begin
            case (r_op)
                OP_AVG_HIGH: r_avg_high <= div_quot[TIME_W-1:0];
                OP_AVG_LOW:  r_avg_low  <= div_quot[TIME_W-1:0];
                OP_PERIOD: begin
                    if (div_quot[DIV_NUM_W-1:PERIOD_W] != '0) begin
                        r_period <= '1;
                    end else begin
                        r_period <= div_quot[PERIOD_W-1:0];
                    end
                end
                OP_FREQ:     r_freq <= div_quot[CLOCK_W-1:0];
                OP_DUTY:     r_duty <= div_quot[DUTY_W-1:0];
                default:     r_duty <= r_duty;
            endcase
        end
    end

    // tick sum, then the two scaled products
    always_ff @(posedge i_clk) begin
        if (i_cmd.sum_ticks) begin
            r_ticks <= TICKS_W'(r_avg_high) + TICKS_W'(r_avg_low);
        end
        if (i_cmd.mul) begin
            r_prod_ns   <= PROD_NS_W'(r_ticks) * PROD_NS_W'(NS_PER_SECOND);
            r_prod_duty <= PROD_DUTY_W'(r_avg_high) * PROD_DUTY_W'(DUTY_SCALE);
        end
    end

    assign no_signal = (r_high_valid == '0) && (r_low_valid == '0);

    // output word register
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            if (no_signal) begin
                r_out_word <= '{period_ns: '0, frequency_hz: '0, duty_hundredths: '0,
                                no_signal: 1'b1};
            end else begin
                r_out_word <= '{period_ns: r_period, frequency_hz: r_freq,
                                duty_hundredths: r_duty, no_signal: 1'b0};
            end
        end
    end

    // status to the controller
    always_comb begin
        o_status.window_end = (r_pair_index == LAST_PAIR);
        o_status.high_zero  = (r_high_valid == '0);
        o_status.low_zero   = (r_low_valid == '0);
        o_status.clock_zero = (r_clock_hz == '0);
        o_status.div_done   = div_done;
    end

    assign o_out_word = r_out_word;

endmodule

>>> rtl/core/pdfm_ctrl.sv
// pwm meter controller: input handshake, window-end divide sequence
// and output valid; depends on pdfm_pkg
`timescale 1ns / 1ps

module pdfm_ctrl (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    input  pdfm_pkg::t_dp_status   i_status,
    output pdfm_pkg::t_ctrl_cmd    o_cmd
);
    import pdfm_pkg::*;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b000_0000_0001,
        S_INIT  = 11'b000_0000_0010,
        S_HIGH  = 11'b000_0000_0100,
        S_LOW   = 11'b000_0000_1000,
        S_SUM   = 11'b000_0001_0000,
        S_MUL   = 11'b000_0010_0000,
        S_SCALE = 11'b000_0100_0000,
        S_PER   = 11'b000_1000_0000,
        S_FREQ  = 11'b001_0000_0000,
        S_DUTY  = 11'b010_0000_0000,
        S_OUT   = 11'b100_0000_0000
    } t_state;

    t_state    r_state;
    t_state    n_state;
    logic      r_out_valid;
    logic      n_out_valid;
    t_ctrl_cmd cmd;
    logic      out_free;

    assign out_free = !r_out_valid || !i_out_stall;

    // next state and commands
    always_comb begin
        n_state       = r_state;
        cmd           = '0;
        cmd.div_op    = OP_AVG_HIGH;
        case (r_state)
            S_IDLE: begin
                cmd.accept = i_in_valid;
                if (i_in_valid && i_status.window_end) begin
                    n_state = S_INIT;
                end
            end
            S_INIT: begin
                cmd.init = 1'b1;
                if (i_status.high_zero && i_status.low_zero) begin
                    n_state = S_OUT;
                end else if (!i_status.high_zero) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_AVG_HIGH;
                    n_state       = S_HIGH;
                end else begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_AVG_LOW;
                    n_state       = S_LOW;
                end
            end
            S_HIGH: begin
                if (i_status.div_done) begin
                    if (!i_status.low_zero) begin
                        cmd.div_start = 1'b1;
                        cmd.div_op    = OP_AVG_LOW;
                        n_state       = S_LOW;
                    end else begin
                        n_state = S_SUM;
                    end
                end
            end
            S_LOW: begin
                if (i_status.div_done) begin
                    n_state = S_SUM;
                end
            end
            S_SUM: begin
                cmd.sum_ticks = 1'b1;
                n_state       = S_MUL;
            end
            S_MUL: begin
                cmd.mul = 1'b1;
                n_state = S_SCALE;
            end
            // products are registered, start the first scaled divide
            S_SCALE: begin
                cmd.div_start = 1'b1;
                if (!i_status.clock_zero) begin
                    cmd.div_op = OP_PERIOD;
                    n_state    = S_PER;
                end else begin
                    cmd.div_op = OP_DUTY;
                    n_state    = S_DUTY;
                end
            end
            S_PER: begin
                if (i_status.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_FREQ;
                    n_state       = S_FREQ;
                end
            end
            S_FREQ: begin
                if (i_status.div_done) begin
                    cmd.div_start = 1'b1;
                    cmd.div_op    = OP_DUTY;
                    n_state       = S_DUTY;
                end
            end
            S_DUTY: begin
                if (i_status.div_done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_free) begin
                    cmd.load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output valid: set on load, cleared when the word is taken
    always_comb begin
        n_out_valid = r_out_valid;
        if (cmd.load) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

>>> rtl/core/pdfm_checker.sv
// pwm meter port checker: output word rules seen at the top level ports
// depends on pdfm_pkg; bound to pwm_duty_frequency_meter below
`timescale 1ns / 1ps

module pdfm_checker (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           o_out_valid,
    input  logic                           i_out_stall,
    input  pdfm_pkg::t_out_word            o_out_word
);
    import pdfm_pkg::*;

    // a stalled output word stays valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("output valid dropped while stalled");

    // a stalled output word does not change
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_word))
        else $error("output word changed while stalled");

    // an empty window reports zeros
    a_no_signal_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.no_signal) |->
            (o_out_word.period_ns == '0) && (o_out_word.frequency_hz == '0) &&
            (o_out_word.duty_hundredths == '0))
        else $error("no-signal word carries nonzero fields");

    // duty never above one hundred percent
    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_word.duty_hundredths <= DUTY_SCALE))
        else $error("duty above full scale");

endmodule

bind pwm_duty_frequency_meter pdfm_checker u_pdfm_checker (.*);
